[design/cpr_pkg.sv]
// ----------------------------------------------------------------------------
// cpr_pkg: shared constants for the Catmull-Rom path sampler
// Field widths, divider and root unit sizes, sample count limits.
// ----------------------------------------------------------------------------
package cpr_pkg;

    localparam int COORD_W     = 32;   // Q16.16 coordinate width
    localparam int SPS_W       = 7;    // samples_per_segment register width
    localparam int SPS_RESET   = 10;   // samples per segment after reset
    localparam int MAX_SAMPLES = 64;   // upper clamp of the sample count
    localparam int DIV_NUM_W   = 56;   // dividend magnitude width
    localparam int DIV_DEN_W   = 20;   // divisor width (2*R^3 fits)
    localparam int RAD_W       = 64;   // radicand width of the root unit

endpackage

[design/cpr_divider.sv]
// ----------------------------------------------------------------------------
// cpr_divider: iterative unsigned restoring divider
// One quotient bit per cycle; done pulses for one cycle with the quotient.
// ----------------------------------------------------------------------------
module cpr_divider #(
    parameter int NUM_W = cpr_pkg::DIV_NUM_W,
    parameter int DEN_W = cpr_pkg::DIV_DEN_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] sh_reg, sh_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;
    logic             fits;

    // shift one dividend bit into the partial remainder
    assign trial = {rem_reg, sh_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            rem_next  = '0;
            sh_next   = num;
            den_next  = den;
        end else if (busy_reg) begin
            rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            sh_next  = {sh_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = sh_reg;

endmodule

[design/cpr_isqrt.sv]
// ----------------------------------------------------------------------------
// cpr_isqrt: iterative integer square root
// Two radicand bits per cycle; done pulses for one cycle with floor(sqrt).
// ----------------------------------------------------------------------------
module cpr_isqrt #(
    parameter int RAD_W = cpr_pkg::RAD_W
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [RAD_W-1:0]   rad,
    output logic               done,
    output logic [RAD_W/2-1:0] root
);
    localparam int STEPS = RAD_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [RAD_W-1:0] s_reg, s_next;
    logic [RAD_W-1:0] res_reg, res_next;
    logic [RAD_W-1:0] probe_reg, probe_next;
    logic [RAD_W:0]   trial;
    logic             fits;

    // compare the remainder against root plus the current probe bit
    assign trial = {1'b0, res_reg} + {1'b0, probe_reg};
    assign fits  = ({1'b0, s_reg} >= trial);

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        s_next     = s_reg;
        res_next   = res_reg;
        probe_next = probe_reg;
        if (start) begin
            busy_next  = 1'b1;
            cnt_next   = CNT_W'(STEPS);
            s_next     = rad;
            res_next   = '0;
            probe_next = {2'b01, {(RAD_W-2){1'b0}}};
        end else if (busy_reg) begin
            if (fits) begin
                s_next   = s_reg - trial[RAD_W-1:0];
                res_next = (res_reg >> 1) + probe_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            probe_next = probe_reg >> 2;
            cnt_next   = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        s_reg     <= s_next;
        res_reg   <= res_next;
        probe_reg <= probe_next;
    end

    assign done = done_reg;
    assign root = res_reg[RAD_W/2-1:0];

endmodule

[design/catmull_rom_path_sampler.sv]
// ----------------------------------------------------------------------------
// catmull_rom_path_sampler: Catmull-Rom spline sampler over a waypoint window
// Keeps the last six waypoints and emits R samples of position and bend
// magnitude for each completed segment, using one shared multiplier, one
// iterative divider and one iterative root unit under a small sequencer.
// ----------------------------------------------------------------------------
// Sequence: for each sample of a segment the sequencer makes 16 multiply steps,
//   four 56-step passes through the shared divider and, unless the bend
//   saturates first, the 32-step root.
// Flow: one item at a time; s_ready is high only between items. Earlier
//   waypoints (fewer than six seen) leave the block idle and ready again.
// Reset: waypoint count cleared, samples_per_segment = 10, window contents
//   undefined until written, no item in flight.
// ----------------------------------------------------------------------------
module catmull_rom_path_sampler (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [cpr_pkg::SPS_W-1:0]          cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [cpr_pkg::COORD_W-1:0] s_point_x,
    input  logic signed [cpr_pkg::COORD_W-1:0] s_point_y,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [cpr_pkg::COORD_W-1:0] m_sample_x,
    output logic signed [cpr_pkg::COORD_W-1:0] m_sample_y,
    output logic [cpr_pkg::COORD_W-1:0]        m_bend_magnitude,
    output logic                               m_segment_end
);
    localparam int NW = cpr_pkg::DIV_NUM_W;
    localparam int DW = cpr_pkg::DIV_DEN_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_R2   = 4'd1;
    localparam logic [3:0] ST_R3   = 4'd2;
    localparam logic [3:0] ST_WA   = 4'd3;
    localparam logic [3:0] ST_WB   = 4'd4;
    localparam logic [3:0] ST_MAC  = 4'd5;
    localparam logic [3:0] ST_DIVS = 4'd6;
    localparam logic [3:0] ST_DIVL = 4'd7;
    localparam logic [3:0] ST_DIVW = 4'd8;
    localparam logic [3:0] ST_SQA  = 4'd9;
    localparam logic [3:0] ST_SQB  = 4'd10;
    localparam logic [3:0] ST_SQC  = 4'd11;
    localparam logic [3:0] ST_SQW  = 4'd12;
    localparam logic [3:0] ST_OUT  = 4'd13;

    logic [3:0]  state_reg;
    logic [6:0]  sps_reg;
    logic [2:0]  seen_reg;
    logic signed [31:0] win_x_reg [6];
    logic signed [31:0] win_y_reg [6];
    logic signed [31:0] wp_x_reg [4];
    logic signed [31:0] wp_y_reg [4];
    logic [6:0]  r_reg;
    logic [12:0] r2_reg;
    logic [18:0] r3_reg;
    logic [5:0]  j_reg;
    logic [11:0] j2_reg;
    logic [17:0] j3_reg, jr2_reg, j2r_reg;
    logic [4:0]  mac_cnt_reg;
    logic signed [55:0] acc_reg [4];
    logic signed [65:0] prod_reg;
    logic [1:0]  div_idx_reg;
    logic signed [56:0] nsum_reg;
    logic        neg_reg [4];
    logic [NW-1:0] q_reg [4];
    logic [63:0] sqa_reg;
    logic [31:0] bend_reg;
    logic        m_valid_reg;
    logic signed [31:0] m_x_reg, m_y_reg;
    logic [31:0] m_bend_reg;
    logic        m_end_reg;

    logic        accept;
    logic [6:0]  r_eff;
    logic        last_sample;
    logic        out_free;

    // effective sample count: zero acts as one, above range clamps
    always_comb begin
        if (sps_reg == 7'd0) begin
            r_eff = 7'd1;
        end else if (sps_reg > 7'(cpr_pkg::MAX_SAMPLES)) begin
            r_eff = 7'(cpr_pkg::MAX_SAMPLES);
        end else begin
            r_eff = sps_reg;
        end
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign last_sample = ({1'b0, j_reg} + 7'd1) == r_reg;
    assign out_free    = !m_valid_reg || m_ready;

    // basis weights for the current sample, scaled by R^3 and by R
    logic signed [23:0] sj, sr, sj3, sj2r, sjr2, sr3;
    logic signed [23:0] w_arr [4];
    logic signed [23:0] c_arr [4];

    assign sj   = $signed(24'(j_reg));
    assign sr   = $signed(24'(r_reg));
    assign sj3  = $signed(24'(j3_reg));
    assign sj2r = $signed(24'(j2r_reg));
    assign sjr2 = $signed(24'(jr2_reg));
    assign sr3  = $signed(24'(r3_reg));

    always_comb begin
        w_arr[0] = -sj3 + 24'sd2 * sj2r - sjr2;
        w_arr[1] = 24'sd3 * sj3 - 24'sd5 * sj2r + 24'sd2 * sr3;
        w_arr[2] = -(24'sd3 * sj3) + 24'sd4 * sj2r + sjr2;
        w_arr[3] = sj3 - sj2r;
        c_arr[0] = -(24'sd6 * sj) + 24'sd4 * sr;
        c_arr[1] = 24'sd18 * sj - 24'sd10 * sr;
        c_arr[2] = -(24'sd18 * sj) + 24'sd8 * sr;
        c_arr[3] = 24'sd6 * sj - 24'sd2 * sr;
    end

    // shared multiplier operand select
    logic [3:0]         term;
    logic [3:0]         prev_term;
    logic signed [31:0] pt;
    logic signed [23:0] wt;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;

    assign term      = mac_cnt_reg[3:0];
    assign prev_term = 4'(mac_cnt_reg - 5'd1);
    assign pt        = term[2] ? wp_y_reg[term[1:0]] : wp_x_reg[term[1:0]];
    assign wt        = term[3] ? c_arr[term[1:0]] : w_arr[term[1:0]];

    always_comb begin
        unique case (state_reg)
            ST_SQA: begin
                mul_a = $signed({1'b0, q_reg[2][31:0]});
                mul_b = $signed({1'b0, q_reg[2][31:0]});
            end
            ST_SQB: begin
                mul_a = $signed({1'b0, q_reg[3][31:0]});
                mul_b = $signed({1'b0, q_reg[3][31:0]});
            end
            default: begin
                mul_a = $signed({pt[31], pt});
                mul_b = $signed({{9{wt[23]}}, wt});
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // divider operands: rounding bias and divisor per quotient
    logic signed [55:0] acc_sel;
    logic [18:0]        bias;
    logic [DW-1:0]      den;
    logic [56:0]        mag;
    logic               div_start, div_done;
    logic [NW-1:0]      div_quo;

    assign acc_sel = acc_reg[div_idx_reg];
    assign bias    = div_idx_reg[1] ? 19'(r_reg) : r3_reg;
    assign den     = div_idx_reg[1] ? DW'({r_reg, 1'b0}) : DW'({r3_reg, 1'b0});
    assign mag     = nsum_reg[56] ? (57'(den) - 57'd1 - 57'(nsum_reg)) : 57'(nsum_reg);
    assign div_start = (state_reg == ST_DIVL);

    cpr_divider #(
        .NUM_W (NW),
        .DEN_W (DW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (mag[NW-1:0]),
        .den     (den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // sum of squares and root
    logic [64:0] sq_sum;
    logic        bend_big;
    logic        sq_start, sq_done;
    logic [31:0] sq_root;

    assign sq_sum   = {1'b0, sqa_reg} + {1'b0, prod_reg[63:0]};
    assign bend_big = (q_reg[2][NW-1:32] != '0) || (q_reg[3][NW-1:32] != '0);
    assign sq_start = (state_reg == ST_SQC) && !sq_sum[64];

    cpr_isqrt #(
        .RAD_W (cpr_pkg::RAD_W)
    ) u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .rad     (sq_sum[63:0]),
        .done    (sq_done),
        .root    (sq_root)
    );

    // signed quotient saturated to the coordinate range
    function automatic logic signed [31:0] sat_pos(input logic neg, input logic [NW-1:0] q);
        logic [NW-1:0] nq;
        nq = -q;
        if (!neg) begin
            sat_pos = (q[NW-1:31] != '0) ? 32'sh7FFFFFFF : $signed(q[31:0]);
        end else if (q > NW'(33'h080000000)) begin
            sat_pos = 32'sh80000000;
        end else begin
            sat_pos = $signed(nq[31:0]);
        end
    endfunction

    // control sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sps_reg     <= 7'(cpr_pkg::SPS_RESET);
            seen_reg    <= '0;
            m_valid_reg <= 1'b0;
            mac_cnt_reg <= '0;
            div_idx_reg <= '0;
            j_reg       <= '0;
        end else begin
            if (cfg_we) begin
                sps_reg <= cfg_wdata;
            end
            // raise valid with a new sample, drop it once the item is taken
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (seen_reg != 3'd6) begin
                            seen_reg <= seen_reg + 3'd1;
                        end
                        if (seen_reg >= 3'd5) begin
                            j_reg     <= '0;
                            state_reg <= ST_R2;
                        end
                    end
                end
                ST_R2: state_reg <= ST_R3;
                ST_R3: state_reg <= ST_WA;
                ST_WA: state_reg <= ST_WB;
                ST_WB: begin
                    mac_cnt_reg <= '0;
                    state_reg   <= ST_MAC;
                end
                ST_MAC: begin
                    mac_cnt_reg <= mac_cnt_reg + 5'd1;
                    if (mac_cnt_reg == 5'd16) begin
                        div_idx_reg <= '0;
                        state_reg   <= ST_DIVS;
                    end
                end
                ST_DIVS: state_reg <= ST_DIVL;
                ST_DIVL: state_reg <= ST_DIVW;
                ST_DIVW: begin
                    if (div_done) begin
                        div_idx_reg <= div_idx_reg + 2'd1;
                        state_reg   <= (div_idx_reg == 2'd3) ? ST_SQA : ST_DIVS;
                    end
                end
                ST_SQA: state_reg <= bend_big ? ST_OUT : ST_SQB;
                ST_SQB: state_reg <= ST_SQC;
                ST_SQC: state_reg <= sq_sum[64] ? ST_OUT : ST_SQW;
                ST_SQW: begin
                    if (sq_done) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        j_reg     <= j_reg + 6'd1;
                        state_reg <= last_sample ? ST_IDLE : ST_WA;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        // shift the waypoint window; latch the segment's four points
        if (accept) begin
            for (int k = 5; k > 0; k--) begin
                win_x_reg[k] <= win_x_reg[k-1];
                win_y_reg[k] <= win_y_reg[k-1];
            end
            win_x_reg[0] <= s_point_x;
            win_y_reg[0] <= s_point_y;
            wp_x_reg[0]  <= (seen_reg == 3'd5) ? win_x_reg[4] : win_x_reg[5];
            wp_y_reg[0]  <= (seen_reg == 3'd5) ? win_y_reg[4] : win_y_reg[5];
            wp_x_reg[1]  <= win_x_reg[4];
            wp_y_reg[1]  <= win_y_reg[4];
            wp_x_reg[2]  <= win_x_reg[3];
            wp_y_reg[2]  <= win_y_reg[3];
            wp_x_reg[3]  <= win_x_reg[2];
            wp_y_reg[3]  <= win_y_reg[2];
            r_reg        <= r_eff;
        end
        if (state_reg == ST_R2) begin
            r2_reg <= 13'(r_reg * r_reg);
        end
        if (state_reg == ST_R3) begin
            r3_reg <= 19'(r2_reg * r_reg);
        end
        if (state_reg == ST_WA) begin
            j2_reg  <= 12'(j_reg * j_reg);
            jr2_reg <= 18'(j_reg * r2_reg);
        end
        if (state_reg == ST_WB) begin
            j3_reg  <= 18'(j2_reg * j_reg);
            j2r_reg <= 18'(j2_reg * r_reg);
            for (int a = 0; a < 4; a++) begin
                acc_reg[a] <= '0;
            end
        end
        // multiply one term, accumulate the previous one
        if (state_reg == ST_MAC) begin
            prod_reg <= mul_p;
            if (mac_cnt_reg != 5'd0) begin
                acc_reg[prev_term[3:2]] <= acc_reg[prev_term[3:2]]
                                           + $signed(prod_reg[55:0]);
            end
        end
        if (state_reg == ST_SQA || state_reg == ST_SQB) begin
            prod_reg <= mul_p;
        end
        if (state_reg == ST_SQB) begin
            sqa_reg <= prod_reg[63:0];
        end
        // add the rounding bias before division
        if (state_reg == ST_DIVS) begin
            nsum_reg <= 57'(acc_sel) + $signed({38'b0, bias});
        end
        if (state_reg == ST_DIVW && div_done) begin
            q_reg[div_idx_reg]   <= div_quo;
            neg_reg[div_idx_reg] <= nsum_reg[56];
        end
        if (state_reg == ST_SQA && bend_big) begin
            bend_reg <= 32'hFFFFFFFF;
        end
        if (state_reg == ST_SQC && sq_sum[64]) begin
            bend_reg <= 32'hFFFFFFFF;
        end
        if (state_reg == ST_SQW && sq_done) begin
            bend_reg <= sq_root;
        end
        // load the output register
        if (state_reg == ST_OUT && out_free) begin
            m_x_reg    <= sat_pos(neg_reg[0], q_reg[0]);
            m_y_reg    <= sat_pos(neg_reg[1], q_reg[1]);
            m_bend_reg <= bend_reg;
            m_end_reg  <= last_sample;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_sample_x       = m_x_reg;
    assign m_sample_y       = m_y_reg;
    assign m_bend_magnitude = m_bend_reg;
    assign m_segment_end    = m_end_reg;

    // an early waypoint leaves the block ready again at once
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && seen_reg < 3'd5) |=> s_ready)
        else $error("block not ready after an early waypoint");

    // the divider finishes only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIVW))
        else $error("divider result outside its wait state");

    // the root unit finishes only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        sq_done |-> (state_reg == ST_SQW))
        else $error("root result outside its wait state");

endmodule
